FILE: rtl/core/bpa_pkg.sv
`timescale 1ns / 1ps
package bpa_pkg;

    // fixed field widths
    localparam int OP_W  = 2;
    localparam int PG_W  = 10;
    localparam int ORD_W = 4;
    localparam int ST_W  = 3;

    // parameter defaults
    localparam int NUM_PAGES_DEF = 1024;
    localparam int MAX_ORDER_DEF = 10;

    // operation codes
    localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
    localparam logic [OP_W-1:0] OP_FREE    = 2'd1;
    localparam logic [OP_W-1:0] OP_RESERVE = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    // status codes
    localparam logic [ST_W-1:0] ST_OK       = 3'd0;
    localparam logic [ST_W-1:0] ST_NOMEM    = 3'd1;
    localparam logic [ST_W-1:0] ST_BADORDER = 3'd2;
    localparam logic [ST_W-1:0] ST_MISALIGN = 3'd3;
    localparam logic [ST_W-1:0] ST_DOUBLE   = 3'd4;
    localparam logic [ST_W-1:0] ST_NOTFREE  = 3'd5;

    // order register update
    typedef enum logic [2:0] {
        K_HOLD, K_ZERO, K_ORD, K_INC, K_DEC
    } t_kop;

    // index register update
    typedef enum logic [2:0] {
        I_HOLD, I_ZERO, I_INC, I_SHL, I_SHR, I_PK, I_PORD
    } t_iop;

    // controller to datapath
    typedef struct packed {
        logic            load;
        t_kop            k_op;
        t_iop            i_op;
        logic            rd;
        logic            wr;
        logic            wdata;
        logic            buddy;
        logic            clr_wr;
        logic            set_pg;
        logic            st_we;
        logic [ST_W-1:0] st;
        logic            push;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            bad_ord;
        logic            misal;
        logic            i_end;
        logic            k_max;
        logic            k_is_ord;
        logic            k_zero;
        logic            i_at_hi;
        logic            rd_free;
        logic            clr_last;
        logic            out_full;
    } t_sts;

    // first map entry of order k
    function automatic int base_of(int n, int k);
        int b;
        b = 0;
        for (int j = 0; j < k; j++) begin
            b = b + (n >> j);
        end
        return b;
    endfunction

endpackage

FILE: rtl/core/bpa_in_if.sv
`timescale 1ns / 1ps
interface bpa_in_if import bpa_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [PG_W-1:0]  page_number;
    logic [ORD_W-1:0] order;

    modport source (output valid, output op, output page_number, output order, input ready);
    modport sink   (input valid, input op, input page_number, input order, output ready);
endinterface

FILE: rtl/core/bpa_out_if.sv
`timescale 1ns / 1ps
interface bpa_out_if import bpa_pkg::*; ();
    logic            valid;
    logic            ready;
    logic [ST_W-1:0] status;
    logic [PG_W-1:0] page_number_res;

    modport source (output valid, output status, output page_number_res, input ready);
    modport sink   (input valid, input status, input page_number_res, output ready);
endinterface

FILE: rtl/core/bpa_datapath.sv
`timescale 1ns / 1ps
module bpa_datapath import bpa_pkg::*; #(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    output t_sts             o_sts,
    input  logic [OP_W-1:0]  i_op,
    input  logic [PG_W-1:0]  i_page_number,
    input  logic [ORD_W-1:0] i_order,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [ST_W-1:0]  o_status,
    output logic [PG_W-1:0]  o_page_number_res
);

    localparam int MAP_SIZE = 2 * NUM_PAGES;
    localparam int AW = $clog2(MAP_SIZE);
    localparam int KW = $clog2(MAX_ORDER + 1);
    localparam int W0 = (MAX_ORDER > PG_W) ? MAX_ORDER : PG_W;
    localparam int W1 = ($clog2(NUM_PAGES) > W0) ? $clog2(NUM_PAGES) : W0;
    localparam int IW = W1 + 2;

    logic [AW-1:0]    base_tab [MAX_ORDER+1];
    logic             mem [MAP_SIZE];

    logic [OP_W-1:0]  r_op;
    logic [IW-1:0]    r_p;
    logic [ORD_W-1:0] r_ord;
    logic [KW-1:0]    r_k;
    logic [IW-1:0]    r_i;
    logic [AW-1:0]    r_clr;
    logic [ST_W-1:0]  r_status;
    logic [PG_W-1:0]  r_pg;
    logic             r_rd;
    logic             r_inr;
    logic             r_ovalid;
    logic [ST_W-1:0]  r_ostat;
    logic [PG_W-1:0]  r_opg;

    logic [IW-1:0]    blk_k;
    logic [IW-1:0]    blk_ord;
    logic [IW-1:0]    size;
    logic [IW-1:0]    hi;
    logic [IW-1:0]    idx;
    logic             inr;
    logic [AW-1:0]    addr;

    // map offsets per order
    for (genvar g = 0; g <= MAX_ORDER; g++) begin : g_base
        assign base_tab[g] = AW'(base_of(NUM_PAGES, g));
    end

    // block counts, block bounds and map address
    assign blk_k   = IW'(NUM_PAGES) >> r_k;
    assign blk_ord = IW'(NUM_PAGES) >> r_ord;
    assign size    = IW'(1) << r_ord;
    assign hi      = (r_p + size - IW'(1)) >> r_k;
    assign idx     = i_cmd.buddy ? (r_i ^ IW'(1)) : r_i;
    assign inr     = idx < blk_k;
    assign addr    = base_tab[r_k] + AW'(idx);

    // status to controller
    always_comb begin
        o_sts.op       = r_op;
        o_sts.bad_ord  = 32'(r_ord) > MAX_ORDER;
        o_sts.misal    = ((r_p & (size - IW'(1))) != '0) || ((r_p >> r_ord) >= blk_ord);
        o_sts.i_end    = r_i >= blk_k;
        o_sts.k_max    = 32'(r_k) == MAX_ORDER;
        o_sts.k_is_ord = 32'(r_k) == 32'(r_ord);
        o_sts.k_zero   = r_k == '0;
        o_sts.i_at_hi  = r_i >= hi;
        o_sts.rd_free  = r_rd & r_inr;
        o_sts.clr_last = 32'(r_clr) == MAP_SIZE - 1;
        o_sts.out_full = r_ovalid;
    end

    // free map memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            mem[r_clr] <= 1'b0;
        end else if (i_cmd.wr && inr) begin
            mem[addr] <= i_cmd.wdata;
        end
        if (i_cmd.rd) begin
            r_rd  <= inr ? mem[addr] : 1'b0;
            r_inr <= inr;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= i_op;
            r_p   <= IW'(i_page_number);
            r_ord <= i_order;
            r_pg  <= '0;
        end
        if (i_cmd.set_pg) begin
            r_pg <= PG_W'(r_i << r_ord);
        end
        if (i_cmd.st_we) begin
            r_status <= i_cmd.st;
        end
        case (i_cmd.k_op)
            K_ZERO:  r_k <= '0;
            K_ORD:   r_k <= KW'(r_ord);
            K_INC:   r_k <= r_k + KW'(1);
            K_DEC:   r_k <= r_k - KW'(1);
            default: r_k <= r_k;
        endcase
        case (i_cmd.i_op)
            I_ZERO:  r_i <= '0;
            I_INC:   r_i <= r_i + IW'(1);
            I_SHL:   r_i <= r_i << 1;
            I_SHR:   r_i <= r_i >> 1;
            I_PK:    r_i <= r_p >> r_k;
            I_PORD:  r_i <= r_p >> r_ord;
            default: r_i <= r_i;
        endcase
        if (i_cmd.push) begin
            r_ostat <= r_status;
            r_opg   <= r_pg;
        end
    end

    // clear counter and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.push) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid           = r_ovalid;
    assign o_status          = r_ostat;
    assign o_page_number_res = r_opg;

endmodule

FILE: rtl/core/bpa_ctrl.sv
`timescale 1ns / 1ps
module bpa_ctrl import bpa_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [23:0] {
        S_CLR     = 24'h000001,
        S_IDLE    = 24'h000002,
        S_DISP    = 24'h000004,
        S_AL_RD   = 24'h000008,
        S_AL_CHK  = 24'h000010,
        S_AL_SPL  = 24'h000020,
        S_AL_SW   = 24'h000040,
        S_DC_INIT = 24'h000080,
        S_DC_RD   = 24'h000100,
        S_DC_CHK  = 24'h000200,
        S_FR_INIT = 24'h000400,
        S_FR_WR   = 24'h000800,
        S_MG_RD   = 24'h001000,
        S_MG_CHK  = 24'h002000,
        S_MG_W2   = 24'h004000,
        S_MG_W3   = 24'h008000,
        S_RS_INIT = 24'h010000,
        S_RS_RD   = 24'h020000,
        S_RS_CHK  = 24'h040000,
        S_RS_SPL  = 24'h080000,
        S_RS_SI   = 24'h100000,
        S_RS_SW   = 24'h200000,
        S_DONE    = 24'h400000
    } t_state;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready = r_state == S_IDLE;

    // sequencer
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.k_op = K_HOLD;
        o_cmd.i_op = I_HOLD;
        o_cmd.st   = ST_OK;
        unique case (r_state)
            S_CLR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                o_cmd.st_we = 1'b1;
                unique case (i_sts.op)
                    OP_ALLOC: begin
                        if (i_sts.bad_ord) begin
                            o_cmd.st = ST_BADORDER;
                            n_state  = S_DONE;
                        end else begin
                            o_cmd.k_op = K_ORD;
                            o_cmd.i_op = I_ZERO;
                            n_state    = S_AL_RD;
                        end
                    end
                    OP_FREE: begin
                        if (i_sts.bad_ord) begin
                            o_cmd.st = ST_BADORDER;
                            n_state  = S_DONE;
                        end else if (i_sts.misal) begin
                            o_cmd.st = ST_MISALIGN;
                            n_state  = S_DONE;
                        end else begin
                            o_cmd.k_op = K_ZERO;
                            n_state    = S_DC_INIT;
                        end
                    end
                    OP_RESERVE: begin
                        o_cmd.k_op = K_ZERO;
                        n_state    = S_RS_INIT;
                    end
                    default: n_state = S_DONE;
                endcase
            end
            // allocate: scan orders upward for the first free block
            S_AL_RD: begin
                if (i_sts.i_end) begin
                    if (i_sts.k_max) begin
                        o_cmd.st_we = 1'b1;
                        o_cmd.st    = ST_NOMEM;
                        n_state     = S_DONE;
                    end else begin
                        o_cmd.k_op = K_INC;
                        o_cmd.i_op = I_ZERO;
                    end
                end else begin
                    o_cmd.rd = 1'b1;
                    n_state  = S_AL_CHK;
                end
            end
            S_AL_CHK: begin
                if (i_sts.rd_free) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_AL_SPL;
                end else begin
                    o_cmd.i_op = I_INC;
                    n_state    = S_AL_RD;
                end
            end
            // split down, freeing upper halves
            S_AL_SPL: begin
                if (i_sts.k_is_ord) begin
                    o_cmd.set_pg = 1'b1;
                    n_state      = S_DONE;
                end else begin
                    o_cmd.k_op = K_DEC;
                    o_cmd.i_op = I_SHL;
                    n_state    = S_AL_SW;
                end
            end
            S_AL_SW: begin
                o_cmd.wr    = 1'b1;
                o_cmd.wdata = 1'b1;
                o_cmd.buddy = 1'b1;
                n_state     = S_AL_SPL;
            end
            // free: check every covered block of every order
            S_DC_INIT: begin
                o_cmd.i_op = I_PK;
                n_state    = S_DC_RD;
            end
            S_DC_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DC_CHK;
            end
            S_DC_CHK: begin
                if (i_sts.rd_free) begin
                    o_cmd.st_we = 1'b1;
                    o_cmd.st    = ST_DOUBLE;
                    n_state     = S_DONE;
                end else if (!i_sts.i_at_hi) begin
                    o_cmd.i_op = I_INC;
                    n_state    = S_DC_RD;
                end else if (i_sts.k_max) begin
                    n_state = S_FR_INIT;
                end else begin
                    o_cmd.k_op = K_INC;
                    n_state    = S_DC_INIT;
                end
            end
            S_FR_INIT: begin
                o_cmd.k_op = K_ORD;
                o_cmd.i_op = I_PORD;
                n_state    = S_FR_WR;
            end
            S_FR_WR: begin
                o_cmd.wr    = 1'b1;
                o_cmd.wdata = 1'b1;
                n_state     = S_MG_RD;
            end
            // merge with buddy order by order
            S_MG_RD: begin
                if (i_sts.k_max) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd    = 1'b1;
                    o_cmd.buddy = 1'b1;
                    n_state     = S_MG_CHK;
                end
            end
            S_MG_CHK: begin
                if (i_sts.rd_free) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_MG_W2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MG_W2: begin
                o_cmd.wr    = 1'b1;
                o_cmd.buddy = 1'b1;
                o_cmd.k_op  = K_INC;
                o_cmd.i_op  = I_SHR;
                n_state     = S_MG_W3;
            end
            S_MG_W3: begin
                o_cmd.wr    = 1'b1;
                o_cmd.wdata = 1'b1;
                n_state     = S_MG_RD;
            end
            // reserve: find the free block holding the page
            S_RS_INIT: begin
                o_cmd.i_op = I_PK;
                n_state    = S_RS_RD;
            end
            S_RS_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_RS_CHK;
            end
            S_RS_CHK: begin
                if (i_sts.rd_free) begin
                    o_cmd.wr = 1'b1;
                    n_state  = S_RS_SPL;
                end else if (i_sts.k_max) begin
                    o_cmd.st_we = 1'b1;
                    o_cmd.st    = ST_NOTFREE;
                    n_state     = S_DONE;
                end else begin
                    o_cmd.k_op = K_INC;
                    n_state    = S_RS_INIT;
                end
            end
            S_RS_SPL: begin
                if (i_sts.k_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.k_op = K_DEC;
                    n_state    = S_RS_SI;
                end
            end
            S_RS_SI: begin
                o_cmd.i_op = I_PK;
                n_state    = S_RS_SW;
            end
            S_RS_SW: begin
                o_cmd.wr    = 1'b1;
                o_cmd.wdata = 1'b1;
                o_cmd.buddy = 1'b1;
                n_state     = S_RS_SPL;
            end
            S_DONE: begin
                if (!i_sts.out_full) begin
                    o_cmd.push = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

endmodule

FILE: rtl/core/buddy_page_allocator.sv
`timescale 1ns / 1ps
// binary buddy page allocator
// i_req carries one request word: op (allocate, free block, reserve page),
// page_number and order. o_rsp returns one result word per request:
// status and, for a good allocate, the first page of the block.
// one request is in work at a time; i_req.ready is high only while idle.
// the sequencer steps the single-port free map one read or write at a time:
//   allocate: scans map entries from the asked order upward, then splits
//             down level by level
//   free: checks every covered entry over all orders, then merges with
//         the buddy level by level while the buddy is free
//   reserve: searches order by order, then splits down level by level
//   every request also passes through dispatch and hand-off
// after reset a clearing pass marks everything allocated; no request is
// taken until it ends.
// the result sits in an output register; a stalled receiver holds it there,
// the next request is still taken, and its result waits until the word
// ahead of it leaves.
module buddy_page_allocator import bpa_pkg::*; #(
    parameter int NUM_PAGES = NUM_PAGES_DEF,
    parameter int MAX_ORDER = MAX_ORDER_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bpa_in_if.sink    i_req,
    bpa_out_if.source o_rsp
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    bpa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_req.valid),
        .o_ready (i_req.ready),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    // free map and working registers
    bpa_datapath #(
        .NUM_PAGES (NUM_PAGES),
        .MAX_ORDER (MAX_ORDER)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_op              (i_req.op),
        .i_page_number     (i_req.page_number),
        .i_order           (i_req.order),
        .o_valid           (o_rsp.valid),
        .i_ready           (o_rsp.ready),
        .o_status          (o_rsp.status),
        .o_page_number_res (o_rsp.page_number_res)
    );

    // no request taken right after reset
    a_no_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_req.ready)
        else $error("request taken during clearing pass");

    // only a good allocate returns a page
    a_page_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && (o_rsp.page_number_res != '0) |-> o_rsp.status == ST_OK)
        else $error("page returned with failure status");

    // no new result pushed over a waiting one
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.push |-> !o_rsp.valid)
        else $error("result overwritten");

    // no map access during the clearing pass
    a_clear_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_wr |-> !cmd.wr && !cmd.rd && !i_req.ready)
        else $error("map access during clearing pass");

endmodule

FILE: dv/buddy_page_allocator_tb.sv
`timescale 1ns / 1ps
module buddy_page_allocator_tb import bpa_pkg::*; ();

    localparam int NPG     = NUM_PAGES_DEF;
    localparam int MAXO    = MAX_ORDER_DEF;
    localparam int MAPN    = 2 * NPG;
    localparam int IDLE_LIM = 100000;
    localparam int HOLD_LEN = 10000;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic [PG_W-1:0]  pg;
        logic [ORD_W-1:0] ord;
    } t_req;

    typedef struct packed {
        logic [ST_W-1:0] st;
        logic [PG_W-1:0] pg;
    } t_rsp;

    logic i_clk;
    logic i_rst_n;

    bpa_in_if  req_if ();
    bpa_out_if rsp_if ();

    buddy_page_allocator uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    // predicted pool state
    bit   pool_free [MAPN];
    t_req pending_q [$];
    t_rsp expected_q [$];
    t_req held_q [$];
    int   fail_cnt;
    int   idle_cycles;
    bit   stim_done;
    bit   quiet;
    int   hold_off;
    int   tx_gap;
    int   rx_gap;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int blk_cnt(int k);
        return NPG >> k;
    endfunction

    function automatic int map_base(int k);
        int b;
        b = 0;
        for (int j = 0; j < k; j++) b += blk_cnt(j);
        return b;
    endfunction

    function automatic bit blk_free(int k, int i);
        if (i >= blk_cnt(k)) return 1'b0;
        return pool_free[map_base(k) + i];
    endfunction

    function automatic void blk_set(int k, int i, bit v);
        if (i < blk_cnt(k)) pool_free[map_base(k) + i] = v;
    endfunction

    // compute the result word of one request and update the pool
    function automatic t_rsp pool_apply(t_req r);
        t_rsp res;
        int   k, i, p, o, lo, hi;
        bit   hit;
        res = '{st: ST_OK, pg: '0};
        p = r.pg;
        o = r.ord;
        case (r.op)
            OP_ALLOC: begin
                if (o > MAXO) begin
                    res.st = ST_BADORDER;
                end else begin
                    res.st = ST_NOMEM;
                    hit = 1'b0;
                    for (k = o; k <= MAXO && !hit; k++) begin
                        for (i = 0; i < blk_cnt(k) && !hit; i++) begin
                            if (blk_free(k, i)) begin
                                hit = 1'b1;
                                blk_set(k, i, 1'b0);
                                while (k > o) begin
                                    k--;
                                    i = i << 1;
                                    blk_set(k, i + 1, 1'b1);
                                end
                                res.st = ST_OK;
                                res.pg = PG_W'(i << o);
                            end
                        end
                    end
                end
            end
            OP_FREE: begin
                if (o > MAXO) begin
                    res.st = ST_BADORDER;
                end else if ((p & ((1 << o) - 1)) != 0 || (p >> o) >= blk_cnt(o)) begin
                    res.st = ST_MISALIGN;
                end else begin
                    hit = 1'b0;
                    for (k = 0; k <= MAXO; k++) begin
                        lo = p >> k;
                        hi = (p + (1 << o) - 1) >> k;
                        for (i = lo; i <= hi; i++) if (blk_free(k, i)) hit = 1'b1;
                    end
                    if (hit) begin
                        res.st = ST_DOUBLE;
                    end else begin
                        k = o;
                        i = p >> o;
                        blk_set(k, i, 1'b1);
                        // merge with buddy while it is free
                        while (k < MAXO && blk_free(k, i ^ 1)) begin
                            blk_set(k, i, 1'b0);
                            blk_set(k, i ^ 1, 1'b0);
                            i = i >> 1;
                            k++;
                            blk_set(k, i, 1'b1);
                        end
                    end
                end
            end
            OP_RESERVE: begin
                res.st = ST_NOTFREE;
                hit = 1'b0;
                for (k = 0; k <= MAXO && !hit; k++) begin
                    if (blk_free(k, p >> k)) begin
                        hit = 1'b1;
                        blk_set(k, p >> k, 1'b0);
                        while (k > 0) begin
                            k--;
                            blk_set(k, (p >> k) ^ 1, 1'b1);
                        end
                        res.st = ST_OK;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_req mk(logic [OP_W-1:0] op, int pg, int ord);
        return '{op: op, pg: PG_W'(pg), ord: ORD_W'(ord)};
    endfunction

    // random request, mostly well-formed frees and allocates
    function automatic t_req rnd_req();
        int sel, o;
        sel = $urandom_range(0, 99);
        o = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 4);
        if (sel < 35) return mk(OP_ALLOC, $urandom_range(0, 1023), o);
        if (sel < 75) return mk(OP_FREE, ($urandom_range(0, 1023) >> o) << o, o);
        if (sel < 82) return mk(OP_FREE, $urandom_range(0, 1023), $urandom_range(0, 15));
        if (sel < 95) return mk(OP_RESERVE, $urandom_range(0, 1023), $urandom_range(0, 15));
        return mk(OP_NOP, $urandom_range(0, 1023), $urandom_range(0, 15));
    endfunction

    // stimulus
    initial begin
        pending_q.push_back(mk(OP_ALLOC, 0, 0));
        pending_q.push_back(mk(OP_RESERVE, 1023, 0));
        pending_q.push_back(mk(OP_FREE, 0, 10));
        pending_q.push_back(mk(OP_FREE, 0, 10));
        pending_q.push_back(mk(OP_FREE, 512, 9));
        pending_q.push_back(mk(OP_ALLOC, 0, 11));
        pending_q.push_back(mk(OP_FREE, 0, 15));
        pending_q.push_back(mk(OP_ALLOC, 0, 10));
        pending_q.push_back(mk(OP_ALLOC, 0, 0));
        pending_q.push_back(mk(OP_FREE, 0, 0));
        pending_q.push_back(mk(OP_FREE, 3, 1));
        pending_q.push_back(mk(OP_FREE, 1023, 0));
        pending_q.push_back(mk(OP_FREE, 1022, 1));
        pending_q.push_back(mk(OP_RESERVE, 1023, 15));
        pending_q.push_back(mk(OP_RESERVE, 1023, 0));
        pending_q.push_back(mk(OP_NOP, 1023, 15));
        pending_q.push_back(mk(OP_ALLOC, 1023, 3));
        pending_q.push_back(mk(OP_FREE, 1008, 4));
        pending_q.push_back(mk(OP_RESERVE, 512, 0));
        pending_q.push_back(mk(OP_ALLOC, 0, 10));
        pending_q.push_back(mk(OP_FREE, 0, 10));
        pending_q.push_back(mk(OP_ALLOC, 0, 9));
        for (int n = 0; n < 950; n++) pending_q.push_back(rnd_req());
    end

    // reset and end of run
    initial begin
        i_rst_n = 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_done && expected_q.size() == 0);
        repeat (50) @(posedge i_clk);
        if (fail_cnt == 0 && expected_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid       <= 1'b0;
            req_if.op          <= OP_NOP;
            req_if.page_number <= '0;
            req_if.order       <= '0;
            tx_gap             <= 0;
            stim_done          <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_q.push_back(pool_apply(held_q.pop_front()));
            end
            if (req_if.valid && !req_if.ready) begin
                // hold the word
            end else if (tx_gap > 0) begin
                tx_gap       <= tx_gap - 1;
                req_if.valid <= 1'b0;
            end else if (pending_q.size() > 0 && !quiet && $urandom_range(0, 9) == 0) begin
                tx_gap       <= $urandom_range(0, 6);
                req_if.valid <= 1'b0;
            end else if (pending_q.size() > 0) begin
                t_req r;
                r = pending_q.pop_front();
                held_q.push_back(r);
                req_if.valid       <= 1'b1;
                req_if.op          <= r.op;
                req_if.page_number <= r.pg;
                req_if.order       <= r.ord;
            end else begin
                req_if.valid <= 1'b0;
                stim_done    <= 1'b1;
            end
        end
    end

    // result receiver and checker
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            rx_gap       <= 0;
            hold_off     <= 0;
            fail_cnt     <= 0;
            quiet        <= 1'b0;
        end else begin
            quiet <= (pending_q.size() < 150);
            if (rsp_if.valid && rsp_if.ready) begin
                if (expected_q.size() == 0) begin
                    $display("%0t: unexpected word st=%0d pg=%0d", $time,
                             rsp_if.status, rsp_if.page_number_res);
                    fail_cnt <= fail_cnt + 1;
                end else begin
                    t_rsp e;
                    bit   bad;
                    e = expected_q.pop_front();
                    bad = 1'b0;
                    if (rsp_if.status !== e.st) begin
                        $display("%0t: status expected %0d actual %0d", $time, e.st,
                                 rsp_if.status);
                        bad = 1'b1;
                    end
                    if (rsp_if.page_number_res !== e.pg) begin
                        $display("%0t: page expected %0d actual %0d", $time, e.pg,
                                 rsp_if.page_number_res);
                        bad = 1'b1;
                    end
                    if (bad) fail_cnt <= fail_cnt + 1;
                end
            end
            // long hold-off once, early in the random part
            if (hold_off == 0 && pending_q.size() == 800) begin
                hold_off     <= HOLD_LEN;
                rsp_if.ready <= 1'b0;
            end else if (hold_off > 1) begin
                hold_off     <= hold_off - 1;
                rsp_if.ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap       <= rx_gap - 1;
                rsp_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rx_gap       <= $urandom_range(0, 6);
                rsp_if.ready <= 1'b0;
            end else begin
                if (hold_off == 1) hold_off <= -1;
                rsp_if.ready <= 1'b1;
            end
        end
    end

    // watchdog on accepted words
    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIM) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

endmodule
